[rtl/internet_checksum_engine_defines.svh]
// Assertion macros used by the top-level checksum engine module.
`ifndef INTERNET_CHECKSUM_ENGINE_DEFINES_SVH
`define INTERNET_CHECKSUM_ENGINE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ICE_ASSERT_SAME(label, clock, rstn, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ICE_ASSERT_NEXT(label, clock, rstn, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/ice_pkg.sv]
// Types, register codes and helper functions of the Internet checksum engine.
`default_nettype none

package ice_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned WORD_W    = 16;
	localparam int unsigned TOTAL_W   = WORD_W + 2;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [WORD_W-1:0] ALL_ONES = 16'hFFFF;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INCLUDE_PSEUDO  = 2'd0,
		CFG_ZERO_TO_ONES    = 2'd1,
		CFG_PROTOCOL_NUMBER = 2'd2
	} ice_cfg_index_t;

	// Current configuration register contents.
	typedef struct packed {
		logic              include_pseudo;
		logic              zero_to_ones;
		logic [BYTE_W-1:0] protocol_number;
	} ice_cfg_t;

	// Record handed from the accumulator to the finishing stages at packet end.
	typedef struct packed {
		logic [WORD_W-1:0] sum;
		logic [WORD_W-1:0] pad;
		logic [WORD_W-1:0] length;
	} ice_tail_t;

	// One finished result.
	typedef struct packed {
		logic [WORD_W-1:0] length;
		logic [WORD_W-1:0] checksum;
	} ice_result_t;

	// One's complement add with end-around carry.
	function automatic logic [WORD_W-1:0] oc_add(input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b);
		logic [WORD_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
	endfunction

endpackage

`default_nettype wire

[rtl/internet_checksum_engine.sv]
// A packet's last byte is registered into the tail stage, then the sum stage, then the
// result register. Throughput: one byte per cycle while the tail stage can take a record;
// back-to-back packets give up to one result per cycle. The limit is the single
// end-around-carry add per byte in the accumulator. Stalls on the result side fill the
// three result stages before input stops. Reset (arst_n low, asynchronous) clears the sums,
// counters, valid flags and configuration registers; the payload registers are not reset.
`default_nettype none
`include "internet_checksum_engine_defines.svh"

module internet_checksum_engine (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Input byte stream.
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [7:0]                     s_tdata,   // [7:0] data_byte
	input  wire logic [0:0]                     s_tuser,   // [0] is_address
	input  wire logic                           s_tlast,   // last_byte
	// Result stream.
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [31:0]                         m_tdata,   // [15:0] checksum, [31:16] data_length
	// Configuration writes.
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [ice_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ice_pkg::BYTE_W-1:0]     cfg_data
);
	import ice_pkg::*;

	ice_cfg_t    cfg;
	ice_tail_t   tail;
	ice_result_t res;
	logic        tail_valid;
	logic        tail_ready;

	ice_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ice_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.data_byte  (s_tdata),
		.is_address (s_tuser[0]),
		.last_byte  (s_tlast),
		.tail_valid (tail_valid),
		.tail_ready (tail_ready),
		.tail       (tail)
	);

	ice_finish u_finish (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.tail_valid (tail_valid),
		.tail_ready (tail_ready),
		.tail       (tail),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res        (res)
	);

	assign m_tdata = res;

	// A transferred last byte always lands in the tail stage.
	`ICE_ASSERT_NEXT(a_last_to_tail, clk, arst_n, s_tvalid && s_tready && s_tlast, tail_valid, "last byte lost before tail stage")

	// Input back-pressure only comes from an occupied tail stage.
	`ICE_ASSERT_SAME(a_ready_cause, clk, arst_n, !s_tready, tail_valid, "input stalled with empty tail stage")

	// A stalled tail record keeps its contents.
	`ICE_ASSERT_NEXT(a_tail_hold, clk, arst_n, tail_valid && !tail_ready, tail_valid && $stable(tail), "stalled tail record changed")

endmodule

`default_nettype wire

[rtl/ice_cfg_regs.sv]
// Configuration register bank of the checksum engine.
`default_nettype none

module ice_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [ice_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ice_pkg::BYTE_W-1:0]     cfg_data,
	output ice_pkg::ice_cfg_t                   cfg
);
	import ice_pkg::*;

	ice_cfg_t cfg_q;

	// Writes are always taken; an unknown index is dropped.
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (ice_cfg_index_t'(cfg_index))
				CFG_INCLUDE_PSEUDO: begin
					cfg_q.include_pseudo <= cfg_data[0];
				end
				CFG_ZERO_TO_ONES: begin
					cfg_q.zero_to_ones <= cfg_data[0];
				end
				CFG_PROTOCOL_NUMBER: begin
					cfg_q.protocol_number <= cfg_data;
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/ice_accum.sv]
// Byte pairing, running one's complement sum and payload counter.
`default_nettype none

module ice_accum (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [ice_pkg::BYTE_W-1:0] data_byte,
	input  wire logic                       is_address,
	input  wire logic                       last_byte,
	output logic                            tail_valid,
	input  wire logic                       tail_ready,
	output ice_pkg::ice_tail_t              tail
);
	import ice_pkg::*;

	logic [WORD_W-1:0] word_sum_q;
	logic [WORD_W-1:0] count_q;
	logic [BYTE_W-1:0] hold_q;
	logic              odd_q;
	logic              valid_s1;
	ice_tail_t         tail_s1;

	logic              accept;
	logic [WORD_W-1:0] sum_next;
	logic [WORD_W-1:0] count_next;
	logic [WORD_W-1:0] pad_next;

	// The tail stage frees up when it is empty or drains this cycle.
	assign in_ready   = !valid_s1 || tail_ready;
	assign accept     = in_valid && in_ready;
	assign tail_valid = valid_s1;
	assign tail       = tail_s1;

	// Complete a pair on the second byte; a lone first byte becomes the pad word.
	always_comb begin
		sum_next   = odd_q ? oc_add(word_sum_q, {hold_q, data_byte}) : word_sum_q;
		count_next = is_address ? count_q : count_q + 16'd1;
		pad_next   = odd_q ? '0 : {data_byte, {BYTE_W{1'b0}}};
	end

	// Running state; a packet end starts the next packet from zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_sum_q <= '0;
			count_q    <= '0;
			odd_q      <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				word_sum_q <= '0;
				count_q    <= '0;
				odd_q      <= 1'b0;
			end else begin
				word_sum_q <= sum_next;
				count_q    <= count_next;
				odd_q      <= !odd_q;
			end
		end
	end

	// Held high byte is only read while a pair is open.
	always_ff @(posedge clk) begin
		if (accept && !odd_q) begin
			hold_q <= data_byte;
		end
	end

	// Tail stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && last_byte) begin
			valid_s1 <= 1'b1;
		end else if (tail_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// Tail stage payload.
	always_ff @(posedge clk) begin
		if (accept && last_byte) begin
			tail_s1.sum    <= sum_next;
			tail_s1.pad    <= pad_next;
			tail_s1.length <= count_next;
		end
	end

endmodule

`default_nettype wire

[rtl/ice_finish.sv]
// Pad and pseudo-header addition, fold, complement and result register.
`default_nettype none

module ice_finish (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ice_pkg::ice_cfg_t  cfg,
	input  wire logic          tail_valid,
	output logic               tail_ready,
	input  wire ice_pkg::ice_tail_t tail,
	output logic               res_valid,
	input  wire logic          res_ready,
	output ice_pkg::ice_result_t res
);
	import ice_pkg::*;

	logic               valid_s2;
	logic [TOTAL_W-1:0] total_s2;
	logic [WORD_W-1:0]  length_s2;
	logic               out_valid_q;
	ice_result_t        out_q;

	logic               s2_ready;
	logic [WORD_W-1:0]  proto_word;
	logic [WORD_W-1:0]  len_word;
	logic [TOTAL_W-1:0] total;
	logic [WORD_W:0]    fold1;
	logic [WORD_W-1:0]  fold2;
	logic [WORD_W-1:0]  cks;

	// Each stage moves on when the one after it is empty or draining.
	assign s2_ready   = !out_valid_q || res_ready;
	assign tail_ready = !valid_s2 || s2_ready;
	assign res_valid  = out_valid_q;
	assign res        = out_q;

	// Plain sum of all remaining terms; the end-around carries come in the fold.
	always_comb begin
		proto_word = cfg.include_pseudo ? {{(WORD_W-BYTE_W){1'b0}}, cfg.protocol_number} : '0;
		len_word   = cfg.include_pseudo ? tail.length : '0;
		total      = {2'b00, tail.sum} + {2'b00, tail.pad}
		           + {2'b00, proto_word} + {2'b00, len_word};
	end

	// Fold twice, complement, and optionally map zero to all ones.
	always_comb begin
		fold1 = {1'b0, total_s2[WORD_W-1:0]}
		      + {{(WORD_W-1){1'b0}}, total_s2[TOTAL_W-1:WORD_W]};
		fold2 = fold1[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, fold1[WORD_W]};
		cks   = ~fold2;
		if (cfg.zero_to_ones && cks == '0) begin
			cks = ALL_ONES;
		end
	end

	// Valid flags of the sum stage and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (tail_ready) begin
				valid_s2 <= tail_valid;
			end
			if (s2_ready) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (tail_ready && tail_valid) begin
			total_s2  <= total;
			length_s2 <= tail.length;
		end
		if (s2_ready && valid_s2) begin
			out_q.checksum <= cks;
			out_q.length   <= length_s2;
		end
	end

endmodule

`default_nettype wire
